[rtl/bal_pkg.sv]
// Shared types, codes and channel helpers for the BLE advertising controller.
// Used by bal_cfg, bal_step and the top level; depends on nothing.
package bal_pkg;

    typedef enum logic [2:0] {
        SS_IDLE = 3'd0,
        SS_TX   = 3'd1,
        SS_RX   = 3'd2,
        SS_TXSR = 3'd3,
        SS_RXTO = 3'd4
    } sub_state_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_TXADV   = 3'd1,
        ACT_RX      = 3'd2,
        ACT_SCANRSP = 3'd3,
        ACT_OFF     = 3'd4,
        ACT_CONN    = 3'd5,
        ACT_ROUND   = 3'd6,
        ACT_ERR     = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        REQ_START    = 3'd0,
        REQ_RESET    = 3'd1,
        REQ_DONE     = 3'd2,
        REQ_RX_TO    = 3'd3,
        REQ_INTERVAL = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        CFG_CHAN_EN  = 2'd0,
        CFG_OWN_ADDR = 2'd1,
        CFG_OWN_TYPE = 2'd2,
        CFG_INTERVAL = 2'd3
    } cfg_idx_t;

    localparam logic [3:0]  PDU_SCAN_REQ   = 4'd3;
    localparam logic [3:0]  PDU_CONN_REQ   = 4'd5;
    localparam logic [5:0]  CH_NONE        = 6'd0;
    localparam logic [5:0]  CH_37          = 6'd37;
    localparam logic [5:0]  CH_38          = 6'd38;
    localparam logic [5:0]  CH_39          = 6'd39;
    localparam logic [15:0] INTERVAL_RESET = 16'hFFFF;
    localparam logic [25:0] US_PER_MS      = 26'd1000;
    localparam int          CFG_DATA_W     = 48;

    typedef struct packed {
        logic [2:0]  chan_en;
        logic [47:0] own_addr;
        logic        own_type;
        logic [15:0] interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  rx_pdu_type;
        logic        rx_target_type;
        logic        rx_sender_type;
        logic [47:0] rx_target_address;
        logic        rx_crc_good;
    } req_beat_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  channel;
        logic        rx_timer_start;
        logic        rx_timer_stop;
        logic        interval_timer_load;
        logic        interval_timer_stop;
        logic [25:0] interval_us;
        logic        peer_type;
        logic [2:0]  sub_state;
    } rsp_beat_t;

    // First enabled channel of a round, CH_NONE if none is enabled.
    function automatic logic [5:0] first_chan(input logic [2:0] en);
        logic [5:0] ch;
        ch = CH_NONE;
        if (en[0]) ch = CH_37;
        else if (en[1]) ch = CH_38;
        else if (en[2]) ch = CH_39;
        return ch;
    endfunction

    // Next enabled channel after cur, CH_NONE when the round is over.
    function automatic logic [5:0] next_chan(input logic [5:0] cur, input logic [2:0] en);
        logic [5:0] ch;
        ch = CH_NONE;
        if (cur == CH_37) begin
            if (en[1]) ch = CH_38;
            else if (en[2]) ch = CH_39;
        end
        else if (cur == CH_38) begin
            if (en[2]) ch = CH_39;
        end
        return ch;
    endfunction

endpackage

[rtl/bal_if.sv]
// Valid/ready channel interfaces for event beats and result beats.
// Depends on nothing.
interface bal_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [3:0]  rx_pdu_type;
    logic        rx_target_type;
    logic        rx_sender_type;
    logic [47:0] rx_target_address;
    logic        rx_crc_good;

    modport source (output valid, req_type, rx_pdu_type, rx_target_type, rx_sender_type,
                    rx_target_address, rx_crc_good, input ready);
    modport sink (input valid, req_type, rx_pdu_type, rx_target_type, rx_sender_type,
                  rx_target_address, rx_crc_good, output ready);
endinterface

interface bal_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [5:0]  channel;
    logic        rx_timer_start;
    logic        rx_timer_stop;
    logic        interval_timer_load;
    logic        interval_timer_stop;
    logic [25:0] interval_us;
    logic        peer_type;
    logic [2:0]  sub_state;

    modport source (output valid, action, channel, rx_timer_start, rx_timer_stop,
                    interval_timer_load, interval_timer_stop, interval_us, peer_type,
                    sub_state, input ready);
    modport sink (input valid, action, channel, rx_timer_start, rx_timer_stop,
                  interval_timer_load, interval_timer_stop, interval_us, peer_type,
                  sub_state, output ready);
endinterface

[rtl/bal_cfg.sv]
// Configuration register file of the advertising controller.
// Depends on bal_pkg.
module bal_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [bal_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output bal_pkg::cfg_t                  cfg
);
    import bal_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CHAN_EN:  cfg_next.chan_en     = cfg_wdata[2:0];
                CFG_OWN_ADDR: cfg_next.own_addr    = cfg_wdata[47:0];
                CFG_OWN_TYPE: cfg_next.own_type    = cfg_wdata[0];
                CFG_INTERVAL: cfg_next.interval_ms = cfg_wdata[15:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chan_en     <= 3'd0;
            cfg_reg.own_addr    <= 48'd0;
            cfg_reg.own_type    <= 1'b0;
            cfg_reg.interval_ms <= INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

[rtl/bal_step.sv]
// Event decision logic: next sub-state, next channel and the result beat
// for one registered event. Depends on bal_pkg.
module bal_step (
    input  bal_pkg::cfg_t      cfg,
    input  bal_pkg::req_beat_t beat,
    input  bal_pkg::sub_state_t state,
    input  logic [5:0]         cur_chan,
    output bal_pkg::sub_state_t state_next,
    output logic [5:0]         chan_next,
    output bal_pkg::rsp_beat_t rsp
);
    import bal_pkg::*;

    logic [5:0]  first_ch;
    logic [5:0]  next_ch;
    logic        match;
    logic        scan_hit;
    logic        conn_hit;
    logic [25:0] interval_us;

    assign first_ch    = first_chan(cfg.chan_en);
    assign next_ch     = next_chan(cur_chan, cfg.chan_en);
    assign match       = (beat.rx_target_type == cfg.own_type)
                         && (beat.rx_target_address == cfg.own_addr);
    assign scan_hit    = match && (beat.rx_pdu_type == PDU_SCAN_REQ);
    assign conn_hit    = match && (beat.rx_pdu_type == PDU_CONN_REQ) && beat.rx_crc_good;
    assign interval_us = 26'(cfg.interval_ms) * US_PER_MS;

    // Next state and channel.
    always_comb
    begin
        state_next = state;
        chan_next  = cur_chan;
        unique case (req_t'(beat.req_type))
            REQ_START:
            begin
                if (first_ch != CH_NONE)
                begin
                    state_next = SS_TX;
                    chan_next  = first_ch;
                end
            end
            REQ_RESET: state_next = SS_IDLE;
            REQ_DONE:
            begin
                unique case (state)
                    SS_TX: state_next = SS_RX;
                    SS_RX:
                    begin
                        if (scan_hit) state_next = SS_TXSR;
                        else if (conn_hit) state_next = SS_IDLE;
                        else if (next_ch != CH_NONE)
                        begin
                            state_next = SS_TX;
                            chan_next  = next_ch;
                        end
                        else state_next = SS_IDLE;
                    end
                    SS_TXSR, SS_RXTO:
                    begin
                        if (next_ch != CH_NONE)
                        begin
                            state_next = SS_TX;
                            chan_next  = next_ch;
                        end
                        else state_next = SS_IDLE;
                    end
                    default: state_next = state;
                endcase
            end
            REQ_RX_TO: state_next = SS_RXTO;
            REQ_INTERVAL:
            begin
                if (first_ch != CH_NONE)
                begin
                    state_next = SS_TX;
                    chan_next  = first_ch;
                end
                else state_next = SS_IDLE;
            end
            default: state_next = state;
        endcase
    end

    // Result beat; sub_state reports the state after the event.
    always_comb
    begin
        rsp           = '0;
        rsp.sub_state = state_next;
        unique case (req_t'(beat.req_type))
            REQ_START:
            begin
                if (first_ch == CH_NONE) rsp.action = ACT_ERR;
                else
                begin
                    rsp.action              = ACT_TXADV;
                    rsp.channel             = first_ch;
                    rsp.interval_timer_load = 1'b1;
                    rsp.interval_us         = interval_us;
                end
            end
            REQ_RESET: rsp.interval_timer_stop = 1'b1;
            REQ_DONE:
            begin
                unique case (state)
                    SS_TX:
                    begin
                        rsp.action         = ACT_RX;
                        rsp.channel        = cur_chan;
                        rsp.rx_timer_start = 1'b1;
                    end
                    SS_RX:
                    begin
                        rsp.rx_timer_stop = 1'b1;
                        if (scan_hit)
                        begin
                            rsp.action  = ACT_SCANRSP;
                            rsp.channel = cur_chan;
                        end
                        else if (conn_hit)
                        begin
                            rsp.action              = ACT_CONN;
                            rsp.channel             = cur_chan;
                            rsp.interval_timer_stop = 1'b1;
                            rsp.peer_type           = beat.rx_sender_type;
                        end
                        else
                        begin
                            rsp.action  = (next_ch != CH_NONE) ? ACT_TXADV : ACT_ROUND;
                            rsp.channel = next_ch;
                        end
                    end
                    SS_TXSR, SS_RXTO:
                    begin
                        rsp.action  = (next_ch != CH_NONE) ? ACT_TXADV : ACT_ROUND;
                        rsp.channel = next_ch;
                    end
                    default: rsp.action = ACT_NONE;
                endcase
            end
            REQ_RX_TO: rsp.action = ACT_OFF;
            REQ_INTERVAL:
            begin
                rsp.action              = (first_ch != CH_NONE) ? ACT_TXADV : ACT_ROUND;
                rsp.channel             = first_ch;
                rsp.interval_timer_load = 1'b1;
                rsp.interval_us         = interval_us;
            end
            default: rsp.action = ACT_NONE;
        endcase
    end
endmodule

[rtl/ble_advertising_link_fsm.sv]
// BLE advertiser link-layer controller, top level.
// An accepted event beat goes into the input register, and its result beat into
// the result register. One event per cycle is taken; the input register
// advances whenever the result register is empty or being taken.
// Reset clears the configuration to its defaults, the sub-state to idle and the
// current channel to zero; both registers stages come up empty.
module ble_advertising_link_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [bal_pkg::CFG_DATA_W-1:0] cfg_wdata,
    bal_req_if.sink                        req,
    bal_rsp_if.source                      rsp
);
    import bal_pkg::*;

    cfg_t       cfg;
    req_beat_t  in_beat;
    req_beat_t  beat_reg;
    logic       beat_valid_reg;
    rsp_beat_t  rsp_reg;
    rsp_beat_t  rsp_next;
    logic       rsp_valid_reg;
    sub_state_t state_reg;
    sub_state_t state_next;
    logic [5:0] chan_reg;
    logic [5:0] chan_next;
    logic       advance;

    bal_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bal_step u_step (
        .cfg        (cfg),
        .beat       (beat_reg),
        .state      (state_reg),
        .cur_chan   (chan_reg),
        .state_next (state_next),
        .chan_next  (chan_next),
        .rsp        (rsp_next)
    );

    assign in_beat.req_type          = req.req_type;
    assign in_beat.rx_pdu_type       = req.rx_pdu_type;
    assign in_beat.rx_target_type    = req.rx_target_type;
    assign in_beat.rx_sender_type    = req.rx_sender_type;
    assign in_beat.rx_target_address = req.rx_target_address;
    assign in_beat.rx_crc_good       = req.rx_crc_good;

    // The registered event is decided and moved into the result register
    // whenever that register is empty or its beat is being taken.
    assign advance   = beat_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !beat_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            state_reg      <= SS_IDLE;
            chan_reg       <= CH_NONE;
        end
        else
        begin
            if (req.ready) beat_valid_reg <= req.valid;
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
                chan_reg      <= chan_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) beat_reg <= in_beat;
        if (advance) rsp_reg <= rsp_next;
    end

    assign rsp.valid               = rsp_valid_reg;
    assign rsp.action              = rsp_reg.action;
    assign rsp.channel             = rsp_reg.channel;
    assign rsp.rx_timer_start      = rsp_reg.rx_timer_start;
    assign rsp.rx_timer_stop       = rsp_reg.rx_timer_stop;
    assign rsp.interval_timer_load = rsp_reg.interval_timer_load;
    assign rsp.interval_timer_stop = rsp_reg.interval_timer_stop;
    assign rsp.interval_us         = rsp_reg.interval_us;
    assign rsp.peer_type           = rsp_reg.peer_type;
    assign rsp.sub_state           = rsp_reg.sub_state;
endmodule

[tb/ble_advertising_link_fsm_tb.sv]
// Self-checking testbench for the BLE advertising controller: directed channel walks, then
// state-aware random event traffic with random idling, output stalls and sender pauses.
// Depends on bal_pkg, bal_req_if, bal_rsp_if and ble_advertising_link_fsm from the rtl folder.
module ble_advertising_link_fsm_tb;
    import bal_pkg::*;

    localparam int          IDLE_LIMIT = 2000;
    localparam logic [47:0] ADDR_ONES  = 48'hFFFF_FFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bal_req_if req_ch ();
    bal_rsp_if rsp_ch ();

    ble_advertising_link_fsm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow of the controller: configuration and link state.
    logic [2:0]  chan_en_r   = 3'd0;
    logic [47:0] own_addr_r  = '0;
    logic        own_type_r  = 1'b0;
    logic [15:0] interval_r  = INTERVAL_RESET;
    sub_state_t  adv_state   = SS_IDLE;
    logic [7:0]  adv_chan    = 8'd0;

    rsp_beat_t   pending_results[$];
    int          err_count     = 0;
    bit          send_no_idle  = 1'b0;
    bit          recv_no_idle  = 1'b0;
    int          hold_cycles   = 0;
    int          quiet_cycles  = 0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom()};
    endfunction

    function automatic logic [5:0] lowest_enabled();
        if (chan_en_r[0]) return CH_37;
        if (chan_en_r[1]) return CH_38;
        if (chan_en_r[2]) return CH_39;
        return CH_NONE;
    endfunction

    function automatic logic [5:0] following_enabled();
        if (adv_chan == 8'(CH_37)) begin
            if (chan_en_r[1]) return CH_38;
            if (chan_en_r[2]) return CH_39;
        end
        else if (adv_chan == 8'(CH_38)) begin
            if (chan_en_r[2]) return CH_39;
        end
        return CH_NONE;
    endfunction

    // Transmit on ch, or close the round when ch is CH_NONE.
    function automatic void move_to(input logic [5:0] ch, inout rsp_beat_t r);
        if (ch != CH_NONE) begin
            adv_chan  = 8'(ch);
            adv_state = SS_TX;
            r.action  = ACT_TXADV;
            r.channel = ch;
        end
        else begin
            adv_state = SS_IDLE;
            r.action  = ACT_ROUND;
            r.channel = CH_NONE;
        end
    endfunction

    function automatic rsp_beat_t advance_link(input req_beat_t ev);
        rsp_beat_t  r;
        logic [5:0] ch;
        logic       match;
        r = '0;
        case (ev.req_type)
            REQ_START:
            begin
                ch = lowest_enabled();
                if (ch == CH_NONE) r.action = ACT_ERR;
                else
                begin
                    move_to(ch, r);
                    r.interval_timer_load = 1'b1;
                    r.interval_us = 26'(interval_r) * US_PER_MS;
                end
            end
            REQ_RESET:
            begin
                adv_state = SS_IDLE;
                r.interval_timer_stop = 1'b1;
            end
            REQ_DONE:
            begin
                if (adv_state == SS_TX)
                begin
                    adv_state = SS_RX;
                    r.action = ACT_RX;
                    r.channel = adv_chan[5:0];
                    r.rx_timer_start = 1'b1;
                end
                else if (adv_state == SS_TXSR || adv_state == SS_RXTO) move_to(following_enabled(), r);
                else if (adv_state == SS_RX)
                begin
                    match = (ev.rx_target_type == own_type_r) &&
                            (ev.rx_target_address == own_addr_r);
                    r.rx_timer_stop = 1'b1;
                    if (match && ev.rx_pdu_type == PDU_SCAN_REQ)
                    begin
                        adv_state = SS_TXSR;
                        r.action = ACT_SCANRSP;
                        r.channel = adv_chan[5:0];
                    end
                    else if (match && ev.rx_pdu_type == PDU_CONN_REQ && ev.rx_crc_good)
                    begin
                        adv_state = SS_IDLE;
                        r.action = ACT_CONN;
                        r.channel = adv_chan[5:0];
                        r.interval_timer_stop = 1'b1;
                        r.peer_type = ev.rx_sender_type;
                    end
                    else move_to(following_enabled(), r);
                end
            end
            REQ_RX_TO:
            begin
                adv_state = SS_RXTO;
                r.action = ACT_OFF;
            end
            REQ_INTERVAL:
            begin
                move_to(lowest_enabled(), r);
                r.interval_timer_load = 1'b1;
                r.interval_us = 26'(interval_r) * US_PER_MS;
            end
            default: ;
        endcase
        r.sub_state = adv_state;
        return r;
    endfunction

    function automatic req_beat_t make_event(input logic [2:0] rq, input logic [3:0] pdu,
                                             input logic tt, input logic st,
                                             input logic [47:0] addr, input logic crc);
        req_beat_t b;
        b.req_type          = rq;
        b.rx_pdu_type       = pdu;
        b.rx_target_type    = tt;
        b.rx_sender_type    = st;
        b.rx_target_address = addr;
        b.rx_crc_good       = crc;
        return b;
    endfunction

    // Picks the next event from the predicted sub-state so that most rounds run deep;
    // a share of fully random beats is mixed in as noise.
    function automatic req_beat_t shaped_event();
        req_beat_t b;
        int        pick;
        b = make_event(REQ_DONE, 4'($urandom), 1'($urandom), 1'($urandom), rand48(),
                       1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            b.req_type = 3'($urandom);
            return b;
        end
        case (adv_state)
            SS_IDLE:
            begin
                if (pick < 60) b.req_type = REQ_START;
                else if (pick < 85) b.req_type = REQ_INTERVAL;
                else if (pick < 93) b.req_type = REQ_DONE;
                else b.req_type = REQ_RESET;
            end
            SS_RX:
            begin
                if (pick < 22) b.req_type = REQ_RX_TO;
                else
                begin
                    if ($urandom_range(0, 9) < 8)
                    begin
                        b.rx_target_address = own_addr_r;
                        b.rx_target_type = own_type_r;
                    end
                    else if ($urandom_range(0, 1))
                        b.rx_target_address = own_addr_r ^ (48'd1 << $urandom_range(0, 47));
                    pick = $urandom_range(0, 9);
                    if (pick < 4) b.rx_pdu_type = PDU_SCAN_REQ;
                    else if (pick < 8) b.rx_pdu_type = PDU_CONN_REQ;
                    if ($urandom_range(0, 3) != 0) b.rx_crc_good = 1'b1;
                end
            end
            default: b.req_type = (pick < 90) ? REQ_DONE : REQ_INTERVAL;
        endcase
        return b;
    endfunction

    // Offers one event beat and records its expected result once it is accepted.
    task automatic offer_event(input req_beat_t b);
        int gap;
        gap = send_no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.req_type          <= b.req_type;
        req_ch.rx_pdu_type       <= b.rx_pdu_type;
        req_ch.rx_target_type    <= b.rx_target_type;
        req_ch.rx_sender_type    <= b.rx_sender_type;
        req_ch.rx_target_address <= b.rx_target_address;
        req_ch.rx_crc_good       <= b.rx_crc_good;
        do @(posedge clk); while (!req_ch.ready);
        pending_results.push_back(advance_link(b));
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called with the block drained.
    task automatic write_reg(input cfg_idx_t idx, input logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CHAN_EN:  chan_en_r  = val[2:0];
            CFG_OWN_ADDR: own_addr_r = val;
            CFG_OWN_TYPE: own_type_r = val[0];
            CFG_INTERVAL: interval_r = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        offer_event(make_event(REQ_START, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_INTERVAL, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, 4'hF, 1'b1, 1'b1, ADDR_ONES, 1'b1));
        for (int c = REQ_INTERVAL + 1; c < 8; c++)
            offer_event(make_event(3'(c), 4'($urandom), 1'b1, 1'b1, rand48(), 1'b1));
        offer_event(make_event(REQ_RESET, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_RX_TO, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        // The current channel is still zero here, so this closes the round.
        offer_event(make_event(REQ_DONE, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        wait_for_results();
    endtask

    task automatic test_channel_walk();
        write_reg(CFG_CHAN_EN, 48'd7);
        write_reg(CFG_OWN_ADDR, ADDR_ONES);
        write_reg(CFG_OWN_TYPE, 48'd1);
        write_reg(CFG_INTERVAL, 48'd0);
        offer_event(make_event(REQ_START, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, PDU_SCAN_REQ, 1'b1, 1'b0, ADDR_ONES, 1'b0));
        offer_event(make_event(REQ_DONE, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, PDU_SCAN_REQ, 1'b1, 1'b0, ADDR_ONES ^ 48'd1, 1'b1));
        offer_event(make_event(REQ_DONE, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, PDU_CONN_REQ, 1'b1, 1'b1, ADDR_ONES, 1'b1));
        offer_event(make_event(REQ_START, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, 4'hF, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_INTERVAL, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_RX_TO, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        offer_event(make_event(REQ_DONE, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        // Connect request with the wrong address type moves on to the last channel.
        offer_event(make_event(REQ_DONE, PDU_CONN_REQ, 1'b0, 1'b1, ADDR_ONES, 1'b1));
        offer_event(make_event(REQ_RESET, 4'd0, 1'b0, 1'b0, '0, 1'b0));
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        logic [2:0] en;
        for (int p = 0; p < 8; p++)
        begin
            wait_for_results();
            case (p)
                0: en = 3'd7;
                1: en = 3'd1;
                2: en = 3'd0;
                3: en = 3'd4;
                4: en = 3'd2;
                default: en = 3'($urandom);
            endcase
            write_reg(CFG_CHAN_EN, 48'(en));
            write_reg(CFG_OWN_ADDR, (p == 0) ? ADDR_ONES : (p == 1) ? 48'd0 : rand48());
            write_reg(CFG_OWN_TYPE, 48'(p % 2));
            write_reg(CFG_INTERVAL, (p == 0) ? 48'hFFFF : (p == 1) ? 48'd0 : 48'($urandom % 65536));
            send_no_idle = (p == 3);
            recv_no_idle = (p == 3);
            repeat (230) offer_event(shaped_event());
        end
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;
        wait_for_results();
    endtask

    // The receiver holds off while the sender keeps offering back to back.
    task automatic test_output_stall();
        hold_cycles  = 100;
        send_no_idle = 1'b1;
        repeat (40) offer_event(shaped_event());
        send_no_idle = 1'b0;
        wait_for_results();
    endtask

    task automatic test_sender_pause();
        write_reg(CFG_CHAN_EN, 48'd7);
        repeat (40) offer_event(shaped_event());
        wait_for_results();
        repeat (40) offer_event(shaped_event());
    endtask

    initial
    begin
        rst_n                    <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_index                <= CFG_CHAN_EN;
        cfg_wdata                <= '0;
        req_ch.valid             <= 1'b0;
        req_ch.req_type          <= REQ_START;
        req_ch.rx_pdu_type       <= '0;
        req_ch.rx_target_type    <= 1'b0;
        req_ch.rx_sender_type    <= 1'b0;
        req_ch.rx_target_address <= '0;
        req_ch.rx_crc_good       <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_channel_walk();
        test_random_traffic();
        test_output_stall();
        test_sender_pause();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: random ready, long hold-offs on request, and the compare.
    initial
    begin
        rsp_beat_t want;
        rsp_beat_t got;
        int        wait_n;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            wait_n = recv_no_idle ? 0 : $urandom_range(0, 18);
            if (hold_cycles > 0)
            begin
                wait_n += hold_cycles;
                hold_cycles = 0;
            end
            if (wait_n > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            got.action              = rsp_ch.action;
            got.channel             = rsp_ch.channel;
            got.rx_timer_start      = rsp_ch.rx_timer_start;
            got.rx_timer_stop       = rsp_ch.rx_timer_stop;
            got.interval_timer_load = rsp_ch.interval_timer_load;
            got.interval_timer_stop = rsp_ch.interval_timer_stop;
            got.interval_us         = rsp_ch.interval_us;
            got.peer_type           = rsp_ch.peer_type;
            got.sub_state           = rsp_ch.sub_state;
            if (pending_results.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result beat: act=%0d ch=%0d ss=%0d",
                             got.action, got.channel, got.sub_state);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("mismatch want: act=%0d ch=%0d rts=%0d rtp=%0d itl=%0d itp=%0d us=%0d peer=%0d ss=%0d",
                                 want.action, want.channel, want.rx_timer_start,
                                 want.rx_timer_stop, want.interval_timer_load,
                                 want.interval_timer_stop, want.interval_us,
                                 want.peer_type, want.sub_state);
                        $display("         got:  act=%0d ch=%0d rts=%0d rtp=%0d itl=%0d itp=%0d us=%0d peer=%0d ss=%0d",
                                 got.action, got.channel, got.rx_timer_start,
                                 got.rx_timer_stop, got.interval_timer_load,
                                 got.interval_timer_stop, got.interval_us,
                                 got.peer_type, got.sub_state);
                    end
                end
            end
        end
    end

    // Ends the run when neither channel has moved a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
